[rtl/ssc_pkg.sv]
// ---------------------------------------------------------------------------
// ssc_pkg : shared types and constants for the subset-sum counter
// Field widths, default sizing and the item record passed front to back.
// ---------------------------------------------------------------------------
package ssc_pkg;

   localparam int SSC_MAX_SUM    = 255;
   localparam int SSC_COUNT_BITS = 32;

   localparam int SSC_VALUE_W  = 16;
   localparam int SSC_TARGET_W = 8;
   localparam int SSC_WAYS_W   = 32;

   // One classified element: sweep is set when the value fits a partial sum
   typedef struct packed {
      logic [SSC_VALUE_W-1:0] value;
      logic                   last;
      logic                   sweep;
   } ssc_item_type;

endpackage

[rtl/ssc_front.sv]
// ---------------------------------------------------------------------------
// ssc_front : input side of the subset-sum counter
// Takes elements, tags those that can reach a partial sum and holds them in
// a two-entry queue so the input keeps moving while the row sweep runs.
// ---------------------------------------------------------------------------
module ssc_front #(
   parameter int MAX_SUM = ssc_pkg::SSC_MAX_SUM
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ssc_pkg::SSC_VALUE_W-1:0]   req_value,
   input  logic                              req_last,
   output logic                              item_valid,
   input  logic                              item_ready,
   output ssc_pkg::ssc_item_type             item
);
   import ssc_pkg::*;

   ssc_item_type q_ff [2];
   ssc_item_type new_item;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push, pop;

   assign req_ready  = (cnt_ff != 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      new_item.value = req_value;
      new_item.last  = req_last;
      new_item.sweep = (req_value <= SSC_VALUE_W'(MAX_SUM));
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("queue count out of range");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("push without pop did not grow the queue");

   a_class_ok: assert property (@(posedge clock) disable iff (reset)
      item_valid |-> (item.sweep == (item.value <= SSC_VALUE_W'(MAX_SUM))))
      else $error("queued element misclassified");
`endif

endmodule

[rtl/ssc_engine.sv]
// ---------------------------------------------------------------------------
// ssc_engine : row update and result stage of the subset-sum counter
// Sweeps the count row from the top down, adding count[j-v] into count[j]
// with saturation, then reads the target entry and drives the result.
// ---------------------------------------------------------------------------
module ssc_engine #(
   parameter int MAX_SUM    = ssc_pkg::SSC_MAX_SUM,
   parameter int COUNT_BITS = ssc_pkg::SSC_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [ssc_pkg::SSC_TARGET_W-1:0]  csr_wr_data,
   input  logic                              item_valid,
   output logic                              item_ready,
   input  ssc_pkg::ssc_item_type             item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ssc_pkg::SSC_WAYS_W-1:0]    rsp_ways,
   output logic                              rsp_saturated,
   output logic                              rsp_set_done
);
   import ssc_pkg::*;

   localparam int DEPTH = MAX_SUM + 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_SWEEP, ST_DRAIN, ST_TGT, ST_LOOK, ST_EMIT
   } state_type;

   // count row
   logic [COUNT_BITS-1:0] mem [DEPTH];
   logic [AW-1:0]         rd_a_addr, rd_b_addr, wr_addr;
   logic [COUNT_BITS-1:0] rd_a_q, rd_b_q, wr_data;
   logic                  wr_en;

   state_type             state_ff, state_in;
   logic [AW-1:0]         j_ff, j_in;
   logic [AW-1:0]         v_ff, v_in;
   logic                  last_ff, last_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_addr_ff, pend_addr_in;
   logic                  ovf_ff, ovf_in;
   logic [SSC_TARGET_W-1:0] tgt_ff, tgt_in;
   logic [SSC_WAYS_W-1:0] ways_ff, ways_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SSC_WAYS_W-1:0] rsp_ways_ff, rsp_ways_in;
   logic                  rsp_sat_ff, rsp_sat_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic [COUNT_BITS:0]   sum;
   logic                  sum_sat;
   logic [63:0]           rd_ext;
   logic                  tgt_ok;
   logic                  emit_go;

   assign item_ready    = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ways      = rsp_ways_ff;
   assign rsp_saturated = rsp_sat_ff;
   assign rsp_set_done  = rsp_done_ff;

   assign sum     = {1'b0, rd_a_q} + {1'b0, rd_b_q};
   assign sum_sat = sum[COUNT_BITS];
   assign rd_ext  = 64'(rd_a_q);
   assign tgt_ok  = (32'(tgt_ff) <= 32'(MAX_SUM));
   assign emit_go = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign rd_a_addr = (state_ff == ST_TGT) ? AW'(tgt_ff) : j_ff;
   assign rd_b_addr = j_ff - v_ff;

   // clear pass writes the reset row, sweep writes the saturated sums
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = j_ff;
         wr_data = (j_ff == '0) ? COUNT_BITS'(1) : '0;
      end else begin
         wr_en   = pend_ff;
         wr_addr = pend_addr_ff;
         wr_data = sum_sat ? '1 : sum[COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_q <= mem[rd_a_addr];
      rd_b_q <= mem[rd_b_addr];
   end

   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      v_in         = v_ff;
      last_in      = last_ff;
      pend_in      = 1'b0;
      pend_addr_in = j_ff;
      ovf_in       = ovf_ff || (pend_ff && sum_sat);
      tgt_in       = csr_wr_en ? csr_wr_data : tgt_ff;
      ways_in      = ways_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ways_in  = rsp_ways_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_done_in  = rsp_done_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ovf_in = 1'b0;
            if (j_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               j_in = j_ff - AW'(1);
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               last_in = item.last;
               v_in    = AW'(item.value);
               j_in    = AW'(MAX_SUM);
               state_in = item.sweep ? ST_SWEEP : ST_TGT;
            end
         end
         ST_SWEEP: begin
            // reads issued at j and j-v, written back in the following cycle
            pend_in = 1'b1;
            if (j_ff == v_ff) begin
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff - AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_TGT;
         end
         ST_TGT: begin
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (!tgt_ok) begin
               ways_in = '0;
            end else if (rd_ext[63:32] != 32'd0) begin
               ways_in = '1;
            end else begin
               ways_in = rd_ext[31:0];
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_ways_in  = ways_ff;
               rsp_sat_in   = ovf_ff;
               rsp_done_in  = last_ff;
               if (last_ff) begin
                  j_in     = AW'(MAX_SUM);
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         j_ff         <= AW'(MAX_SUM);
         pend_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         tgt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         pend_ff      <= pend_in;
         ovf_ff       <= ovf_in;
         tgt_ff       <= tgt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff         <= v_in;
      last_ff      <= last_in;
      pend_addr_ff <= pend_addr_in;
      ways_ff      <= ways_in;
      rsp_ways_ff  <= rsp_ways_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_done_ff  <= rsp_done_in;
   end

`ifndef ASSERT_OFF
   a_pend_in_sweep: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("row write outside of a sweep");

   a_sweep_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (j_ff >= v_ff))
      else $error("sweep index fell below element value");

   // the sticky flag drops in the cycle after the clear pass starts
   a_set_end_clears: assert property (@(posedge clock) disable iff (reset)
      (emit_go && last_ff) |=> (state_ff == ST_CLEAR && rsp_set_done) ##1 !ovf_ff)
      else $error("end of set did not start the clear pass");
`endif

endmodule

[rtl/subset_sum_count_core.sv]
// ---------------------------------------------------------------------------
// subset_sum_count_core : streaming subset-sum counter
// Counts the subsets of a streamed set that add up to a programmed target.
// ---------------------------------------------------------------------------
// Usage:
//   req_* : one element per transfer (req_value, req_last marks set end).
//   rsp_* : one result per element: rsp_ways is the count at the target for
//           the elements so far, rsp_saturated is sticky within the set,
//           rsp_set_done echoes req_last.
//   csr_* : csr_wr_en/csr_wr_data write the 8-bit target; write only idle.
// Timing:
//   An element with value v <= MAX_SUM is accepted, swept over row
//   entries MAX_SUM down to v, then passes drain, target read, lookup and
//   emit; a larger element skips sweep and drain. The sweep rate is one
//   row entry per cycle, set by the single write port of the count memory.
//   After reset and after every set end the row is rewritten by a clear
//   pass over all MAX_SUM + 1 entries; elements queue in the front meanwhile.
//   A two-entry queue takes elements while the sweep runs. If rsp_ready
//   stays low the result holds in the output register and the engine
//   waits at its emit step; the queue fills and req_ready drops.
// ---------------------------------------------------------------------------
module subset_sum_count_core #(
   parameter int MAX_SUM    = ssc_pkg::SSC_MAX_SUM,
   parameter int COUNT_BITS = ssc_pkg::SSC_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ssc_pkg::SSC_VALUE_W-1:0]   req_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ssc_pkg::SSC_WAYS_W-1:0]    rsp_ways,
   output logic                              rsp_saturated,
   output logic                              rsp_set_done,
   input  logic                              csr_wr_en,
   input  logic [ssc_pkg::SSC_TARGET_W-1:0]  csr_wr_data
);
   import ssc_pkg::*;

   ssc_item_type item;
   logic         item_valid;
   logic         item_ready;

   ssc_front #(
      .MAX_SUM (MAX_SUM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .req_last   (req_last),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   ssc_engine #(
      .MAX_SUM    (MAX_SUM),
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item          (item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ways      (rsp_ways),
      .rsp_saturated (rsp_saturated),
      .rsp_set_done  (rsp_set_done)
   );

endmodule

[bench/ssc_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ssc_checker : scoreboard for the subset-sum counter
// Watches the request, response and csr ports, keeps its own row of subset
// counts and checks every response transfer against the oldest prediction.
// ---------------------------------------------------------------------------
module ssc_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [ssc_pkg::SSC_VALUE_W-1:0]   req_value,
   input  logic                              req_last,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [ssc_pkg::SSC_WAYS_W-1:0]    rsp_ways,
   input  logic                              rsp_saturated,
   input  logic                              rsp_set_done,
   input  logic                              csr_wr_en,
   input  logic [ssc_pkg::SSC_TARGET_W-1:0]  csr_wr_data,
   output int                                fail_count,
   output int                                outstanding,
   output int                                saturated_results
);
   import ssc_pkg::*;

   localparam int ROW_LEN = SSC_MAX_SUM + 1;

   typedef struct packed {
      logic [SSC_WAYS_W-1:0] ways;
      logic                  saturated;
      logic                  set_done;
   } ssc_result_type;

   logic [SSC_COUNT_BITS-1:0] subset_row [ROW_LEN];
   logic                      overflow_seen;
   logic [SSC_TARGET_W-1:0]   target_q;
   ssc_result_type            ways_due [$];
   ssc_result_type            due;
   int                        errors    = 0;
   int                        sat_total = 0;

   function automatic void restart_set();
      for (int k = 0; k < ROW_LEN; k++) subset_row[k] = '0;
      subset_row[0] = 1;
      overflow_seen = 1'b0;
   endfunction

   // 0/1 knapsack update, high sums first so each entry adds the old row
   function automatic ssc_result_type count_subsets(
      input logic [SSC_VALUE_W-1:0] value,
      input logic                   last
   );
      logic [SSC_COUNT_BITS:0] sum;
      ssc_result_type          res;
      if (value <= SSC_MAX_SUM) begin
         for (int j = SSC_MAX_SUM; j >= int'(value); j--) begin
            sum = {1'b0, subset_row[j]} + {1'b0, subset_row[j - int'(value)]};
            if (sum[SSC_COUNT_BITS]) begin
               subset_row[j] = '1;
               overflow_seen = 1'b1;
            end else begin
               subset_row[j] = sum[SSC_COUNT_BITS-1:0];
            end
         end
      end
      res.ways      = subset_row[target_q];
      res.saturated = overflow_seen;
      res.set_done  = last;
      if (last) restart_set();
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         restart_set();
         target_q = '0;
         ways_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (ways_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: expected none, actual ways=%0d sat=%0b done=%0b",
                        $time, rsp_ways, rsp_saturated, rsp_set_done);
            end else begin
               due = ways_due.pop_front();
               if (rsp_ways !== due.ways) begin
                  errors++;
                  $display("%0t: ways mismatch: expected %0d actual %0d",
                           $time, due.ways, rsp_ways);
               end
               if (rsp_saturated !== due.saturated) begin
                  errors++;
                  $display("%0t: saturated mismatch: expected %0b actual %0b",
                           $time, due.saturated, rsp_saturated);
               end
               if (rsp_set_done !== due.set_done) begin
                  errors++;
                  $display("%0t: set_done mismatch: expected %0b actual %0b",
                           $time, due.set_done, rsp_set_done);
               end
               if (due.saturated) sat_total++;
            end
         end
         if (csr_wr_en) target_q = csr_wr_data;
         if (req_valid && req_ready) ways_due.push_back(count_subsets(req_value, req_last));
      end
      // published after the edge so the stimulus side sees a settled count
      fail_count        <= errors;
      outstanding       <= ways_due.size();
      saturated_results <= sat_total;
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb : top level bench for subset_sum_count_core
// Directed sets on the edge values, then random phases of sets with a new
// target per phase and random idle on both sides; results are checked by
// ssc_checker.
// ---------------------------------------------------------------------------
module tb;
   import ssc_pkg::*;

   typedef enum {SET_TYPICAL, SET_ZEROS, SET_NOISE} set_kind_type;

   logic                    clock;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   logic [SSC_VALUE_W-1:0]  req_value   = '0;
   logic                    req_last    = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   logic [SSC_WAYS_W-1:0]   rsp_ways;
   logic                    rsp_saturated;
   logic                    rsp_set_done;
   logic                    csr_wr_en   = 1'b0;
   logic [SSC_TARGET_W-1:0] csr_wr_data = '0;

   int fail_count;
   int outstanding;
   int saturated_results;

   bit quiet        = 1'b0;
   int elems_sent   = 0;
   int sets_sent    = 0;
   int targets_used = 0;

   subset_sum_count_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ways      (rsp_ways),
      .rsp_saturated (rsp_saturated),
      .rsp_set_done  (rsp_set_done),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   ssc_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value         (req_value),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ways          (rsp_ways),
      .rsp_saturated     (rsp_saturated),
      .rsp_set_done      (rsp_set_done),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .saturated_results (saturated_results)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= 34);
   end

   task automatic send_elem(input logic [SSC_VALUE_W-1:0] value, input logic last);
      while (!quiet && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_last  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      elems_sent++;
      if (last) sets_sent++;
   endtask

   // sender holds off until every predicted result has been seen
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_target(input logic [SSC_TARGET_W-1:0] value);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      targets_used++;
   endtask

   function automatic logic [SSC_VALUE_W-1:0] pick_value(input set_kind_type kind);
      int r;
      r = $urandom_range(99);
      case (kind)
         SET_ZEROS: begin
            return (r < 85) ? '0 : SSC_VALUE_W'($urandom_range(1, 3));
         end
         SET_NOISE: begin
            return SSC_VALUE_W'($urandom_range(0, 65535));
         end
         default: begin
            if (r < 40) return SSC_VALUE_W'($urandom_range(0, 24));
            if (r < 75) return SSC_VALUE_W'($urandom_range(0, SSC_MAX_SUM));
            if (r < 85) return ($urandom_range(1) != 0) ? SSC_VALUE_W'(SSC_MAX_SUM) : '0;
            return SSC_VALUE_W'($urandom_range(SSC_MAX_SUM + 1, 65535));
         end
      endcase
   endfunction

   initial begin
      int           phase_no;
      int           phase_len;
      int           set_left;
      int           r;
      set_kind_type kind;

      phase_no = 0;
      set_left = 0;
      kind     = SET_TYPICAL;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // target still at its reset value: zero doubles, oversize values pass
      send_elem(16'd0, 1'b0);
      send_elem(16'hFFFF, 1'b0);
      send_elem(16'd256, 1'b0);
      send_elem(16'd255, 1'b1);

      set_target(8'd255);
      send_elem(16'd255, 1'b0);
      send_elem(16'd0, 1'b0);
      send_elem(16'd128, 1'b0);
      send_elem(16'd127, 1'b0);
      send_elem(16'h8001, 1'b1);

      set_target(8'd1);
      send_elem(16'd1, 1'b0);
      send_elem(16'd1, 1'b0);
      send_elem(16'd0, 1'b0);
      send_elem(16'd1, 1'b1);
      send_elem(16'd1, 1'b1);

      // target changes mid-set, row must carry over
      set_target(8'd128);
      send_elem(16'd64, 1'b0);
      send_elem(16'd64, 1'b0);
      set_target(8'd192);
      send_elem(16'd128, 1'b0);
      send_elem(16'h7FFF, 1'b1);

      while (elems_sent < 1690) begin
         phase_no++;
         r = $urandom_range(99);
         if (r < 15)      set_target(8'd0);
         else if (r < 30) set_target(8'd255);
         else if (r < 65) set_target(SSC_TARGET_W'($urandom_range(0, 40)));
         else             set_target(SSC_TARGET_W'($urandom_range(0, 255)));
         quiet     = (phase_no == 3);
         phase_len = quiet ? 220 : $urandom_range(40, 160);
         repeat (phase_len) begin
            if (set_left == 0) begin
               r = $urandom_range(99);
               if (r < 10) begin
                  kind     = SET_ZEROS;
                  set_left = $urandom_range(34, 44);
               end else if (r < 25) begin
                  kind     = SET_NOISE;
                  set_left = $urandom_range(1, 4);
               end else begin
                  kind     = SET_TYPICAL;
                  set_left = $urandom_range(1, 12);
               end
            end
            send_elem(pick_value(kind), set_left == 1);
            set_left--;
         end
         quiet = 1'b0;
      end

      wait_for_results();
      // room for the trailing clear pass and any stray transfer
      repeat (300) @(posedge clock);

      $display("Covered %0d elements in %0d complete sets over %0d target writes",
               elems_sent, sets_sent, targets_used);
      $display("%0d results reported a saturated count", saturated_results);
      if (fail_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/ssc_pkg.sv
rtl/ssc_front.sv
rtl/ssc_engine.sv
rtl/subset_sum_count_core.sv
bench/ssc_checker.sv
bench/tb.sv
